// ===== rtl/core/pffrs_pkg.sv =====
package pffrs_pkg;

  localparam int MaxPages  = 16;
  localparam int MaxSlots  = 16;
  localparam int PageW     = 4;
  localparam int SlotW     = 4;
  localparam int CountW    = 5;
  localparam int FreeW     = 12;
  localparam int SizeW     = 13;
  localparam int KeyW      = 32;
  localparam int HeaderBytes  = 4 * 4;
  localparam int SlotOverhead = 4;
  localparam logic [FreeW-1:0] FreeLimit = 12'd4080;

  localparam logic [1:0] ModeInsert = 2'd0;
  localparam logic [1:0] ModeSearch = 2'd1;
  localparam logic [1:0] ModeStatus = 2'd2;
  // Requests with this mode are taken and ignored.
  localparam logic [1:0] ModeNone   = 2'd3;

  localparam logic [2:0] OutOk       = 3'd0;
  localparam logic [2:0] OutNoFit    = 3'd1;
  localparam logic [2:0] OutFull     = 3'd2;
  localparam logic [2:0] OutNotFound = 3'd3;
  localparam logic [2:0] OutNoPages  = 3'd4;

  localparam logic [0:0] RegPageSize = 1'd0;

  // Data that travels down the row of page cells, one cell per cycle.
  typedef struct packed {
    logic             act;
    logic [1:0]       mode;
    logic [SizeW-1:0] size;
    logic [KeyW-1:0]  key;
    logic             done;
    logic [PageW-1:0] page;
    logic [SlotW-1:0] slot;
    logic [CountW-1:0] recs;
    logic [FreeW-1:0] free;
  } token_t;

  // Summary each cell reports for status streaming.
  typedef struct packed {
    logic [CountW-1:0] recs;
    logic [FreeW-1:0]  free;
  } page_stat_t;

endpackage

// ===== rtl/core/page_first_fit_record_store_top.sv =====
// Insert and search: a token walks the 16 page cells, one per cycle, and the result is
// taken from the last cell; an insert that fits nowhere appends a new page, if one is left, and is retried.
// Status: one result per page, or a single NoPages result when no page is in use.
// One request at a time; the next is taken in the cycle after the last result transfer.
// Reset (synchronous, rst_n low) empties the page table and sets page_size to 100.
module page_first_fit_record_store_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // mode[1:0], record_size[14:2], record_key[46:15], zero
  input  logic        out_tready,
  output logic        out_tvalid,
  output logic [39:0] out_tdata,  // outcome[2:0], page_index[6:3], slot_index[10:7],
                                  // page_total[15:11], records_in_page[20:16],
                                  // free_bytes[32:21], zero
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [pffrs_pkg::SizeW-1:0] page_size_r;
  pffrs_pkg::token_t           toks [pffrs_pkg::MaxPages+1];
  pffrs_pkg::page_stat_t       stats [pffrs_pkg::MaxPages];
  logic [pffrs_pkg::MaxPages-1:0] in_use, fresh;
  logic [pffrs_pkg::FreeW-1:0] start_free;
  logic [2:0]  oc;
  logic [3:0]  pg, sl;
  logic [4:0]  tot, rc;
  logic [11:0] fr;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[1:0] == {pffrs_pkg::RegPageSize, 1'b0}) ?
                      {19'b0, page_size_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) page_size_r <= pffrs_pkg::SizeW'(100);
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
             cfg_paddr == {pffrs_pkg::RegPageSize, 1'b0})
      page_size_r <= cfg_pwdata[pffrs_pkg::SizeW-1:0];
  end

  pffrs_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .mode(in_tdata[1:0]), .size(in_tdata[14:2]), .key(in_tdata[46:15]),
    .page_size(page_size_r), .tok_head(toks[0]), .tok_tail(toks[pffrs_pkg::MaxPages]),
    .in_use, .fresh, .start_free, .stats, .out_tvalid, .out_tready,
    .o_outcome(oc), .o_page(pg), .o_slot(sl), .o_total(tot), .o_recs(rc),
    .o_free(fr), .o_last(out_tlast)
  );

  for (genvar i = 0; i < pffrs_pkg::MaxPages; i++) begin : g_cell
    pffrs_cell u_cell (
      .clk, .rst_n, .cell_id(pffrs_pkg::PageW'(i)), .in_use(in_use[i]),
      .fresh(fresh[i]), .start_free, .tok_in(toks[i]), .tok_out(toks[i+1]),
      .stat(stats[i])
    );
  end

  assign out_tdata = {7'b0, fr, rc, tot, sl, pg, oc};

endmodule

// ===== rtl/core/pffrs_cell.sv =====
module pffrs_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pffrs_pkg::PageW-1:0]   cell_id,
  input  logic                          in_use,
  input  logic                          fresh,
  input  logic [pffrs_pkg::FreeW-1:0]   start_free,
  input  pffrs_pkg::token_t             tok_in,
  output pffrs_pkg::token_t             tok_out,
  output pffrs_pkg::page_stat_t         stat
);

  logic [pffrs_pkg::CountW-1:0] cnt_r, cnt_nxt;
  logic [pffrs_pkg::FreeW-1:0]  free_r, free_nxt;
  logic [pffrs_pkg::KeyW-1:0]   keys_r [pffrs_pkg::MaxSlots];
  pffrs_pkg::token_t            tok_r, tok_nxt;
  logic [pffrs_pkg::SizeW:0]    need;
  logic                         fits;
  logic                         hit;
  logic [pffrs_pkg::SlotW-1:0]  hit_slot;
  logic                         place;

  always_comb begin
    need = {1'b0, tok_in.size} + (pffrs_pkg::SizeW+1)'(pffrs_pkg::SlotOverhead);
    fits = (need <= {2'b0, free_r}) &&
           (cnt_r < pffrs_pkg::CountW'(pffrs_pkg::MaxSlots));
    hit = 1'b0;
    hit_slot = '0;
    for (int s = pffrs_pkg::MaxSlots - 1; s >= 0; s--) begin
      if ((pffrs_pkg::CountW'(s) < cnt_r) && keys_r[s] == tok_in.key) begin
        hit = 1'b1;
        hit_slot = pffrs_pkg::SlotW'(s);
      end
    end
    place = tok_in.act && !tok_in.done && in_use &&
            tok_in.mode == pffrs_pkg::ModeInsert && fits;
    cnt_nxt = cnt_r;
    free_nxt = free_r;
    tok_nxt = tok_in;
    if (fresh) begin
      cnt_nxt = '0;
      free_nxt = start_free;
    end else if (place) begin
      cnt_nxt = cnt_r + 1'b1;
      free_nxt = free_r - need[pffrs_pkg::FreeW-1:0];
      tok_nxt.done = 1'b1;
      tok_nxt.page = cell_id;
      tok_nxt.slot = cnt_r[pffrs_pkg::SlotW-1:0];
      tok_nxt.recs = cnt_r + 1'b1;
      tok_nxt.free = free_r - need[pffrs_pkg::FreeW-1:0];
    end else if (tok_in.act && !tok_in.done && in_use &&
                 tok_in.mode == pffrs_pkg::ModeSearch && hit) begin
      tok_nxt.done = 1'b1;
      tok_nxt.page = cell_id;
      tok_nxt.slot = hit_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      tok_r.act <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      tok_r <= tok_nxt;
    end
    free_r <= free_nxt;
    if (place) keys_r[cnt_r[pffrs_pkg::SlotW-1:0]] <= tok_in.key;
  end

  assign tok_out = tok_r;
  assign stat = '{recs: cnt_r, free: free_r};

endmodule

// ===== rtl/core/pffrs_ctrl.sv =====
module pffrs_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [1:0]                          mode,
  input  logic [pffrs_pkg::SizeW-1:0]         size,
  input  logic [pffrs_pkg::KeyW-1:0]          key,
  input  logic [pffrs_pkg::SizeW-1:0]         page_size,
  output pffrs_pkg::token_t                   tok_head,
  input  pffrs_pkg::token_t                   tok_tail,
  output logic [pffrs_pkg::MaxPages-1:0]      in_use,
  output logic [pffrs_pkg::MaxPages-1:0]      fresh,
  output logic [pffrs_pkg::FreeW-1:0]         start_free,
  input  pffrs_pkg::page_stat_t               stats [pffrs_pkg::MaxPages],
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [2:0]                          o_outcome,
  output logic [pffrs_pkg::PageW-1:0]         o_page,
  output logic [pffrs_pkg::SlotW-1:0]         o_slot,
  output logic [pffrs_pkg::CountW-1:0]        o_total,
  output logic [pffrs_pkg::CountW-1:0]        o_recs,
  output logic [pffrs_pkg::FreeW-1:0]         o_free,
  output logic                                o_last
);

  typedef enum logic [2:0] {S_IDLE, S_PRE, S_RUN, S_WAIT, S_RETRY, S_STAT, S_OUT} state_t;

  state_t state_r;
  logic [pffrs_pkg::CountW-1:0] used_r;
  logic [1:0]                   mode_r;
  logic [pffrs_pkg::SizeW-1:0]  size_r;
  logic [pffrs_pkg::KeyW-1:0]   key_r;
  logic                         retry_r;
  logic [pffrs_pkg::CountW-1:0] wait_r;
  logic [pffrs_pkg::CountW-1:0] sp_r;
  logic                         ov_r;
  logic [2:0]                   oc_r;
  logic [pffrs_pkg::PageW-1:0]  pg_r;
  logic [pffrs_pkg::SlotW-1:0]  sl_r;
  logic [pffrs_pkg::CountW-1:0] rc_r;
  logic [pffrs_pkg::FreeW-1:0]  fr_r;
  logic                         ls_r;
  logic                         launch;
  logic                         grow;
  logic [pffrs_pkg::SizeW-1:0]  sf_wide;

  assign sf_wide = (page_size > pffrs_pkg::SizeW'(pffrs_pkg::HeaderBytes)) ?
                   page_size - pffrs_pkg::SizeW'(pffrs_pkg::HeaderBytes) : '0;
  assign start_free = (sf_wide > {1'b0, pffrs_pkg::FreeLimit}) ? pffrs_pkg::FreeLimit
                                                               : sf_wide[pffrs_pkg::FreeW-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign launch = (state_r == S_PRE) || (state_r == S_RETRY);
  assign grow = (state_r == S_IDLE && in_tvalid && mode == pffrs_pkg::ModeInsert &&
                 used_r == '0) ||
                (state_r == S_WAIT && wait_r == '0 && !tok_tail.done &&
                 mode_r == pffrs_pkg::ModeInsert && !retry_r &&
                 used_r != pffrs_pkg::CountW'(pffrs_pkg::MaxPages));

  always_comb begin
    for (int i = 0; i < pffrs_pkg::MaxPages; i++) begin
      in_use[i] = pffrs_pkg::CountW'(i) < used_r;
      fresh[i] = grow && (pffrs_pkg::CountW'(i) == used_r);
    end
    tok_head = '0;
    tok_head.act = launch;
    tok_head.mode = mode_r;
    tok_head.size = size_r;
    tok_head.key = key_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r <= '0;
      out_tvalid <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_tvalid) begin
          mode_r <= mode;
          size_r <= size;
          key_r <= key;
          retry_r <= 1'b0;
          if (mode == pffrs_pkg::ModeStatus) begin
            sp_r <= '0;
            state_r <= S_STAT;
          end else if (mode == pffrs_pkg::ModeInsert || mode == pffrs_pkg::ModeSearch) begin
            if (grow) used_r <= used_r + 1'b1;
            state_r <= S_PRE;
          end
        end
        S_PRE, S_RETRY: begin
          wait_r <= pffrs_pkg::CountW'(pffrs_pkg::MaxPages - 1);
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (wait_r != '0) begin
            wait_r <= wait_r - 1'b1;
          end else begin
            state_r <= S_OUT;
            out_tvalid <= 1'b1;
            ls_r <= 1'b1;
            pg_r <= tok_tail.page;
            sl_r <= tok_tail.slot;
            rc_r <= tok_tail.recs;
            fr_r <= tok_tail.free;
            oc_r <= pffrs_pkg::OutOk;
            if (!tok_tail.done) begin
              pg_r <= '0; sl_r <= '0; rc_r <= '0; fr_r <= '0;
              if (mode_r == pffrs_pkg::ModeSearch) oc_r <= pffrs_pkg::OutNotFound;
              else if (retry_r) oc_r <= pffrs_pkg::OutNoFit;
              else if (!grow) oc_r <= pffrs_pkg::OutFull;
              else begin
                used_r <= used_r + 1'b1;
                retry_r <= 1'b1;
                out_tvalid <= 1'b0;
                state_r <= S_RETRY;
              end
            end
          end
        end
        S_STAT: begin
          out_tvalid <= 1'b1;
          state_r <= S_OUT;
          sl_r <= '0;
          if (used_r == '0) begin
            oc_r <= pffrs_pkg::OutNoPages;
            pg_r <= '0; rc_r <= '0; fr_r <= '0; ls_r <= 1'b1;
          end else begin
            oc_r <= pffrs_pkg::OutOk;
            pg_r <= sp_r[pffrs_pkg::PageW-1:0];
            rc_r <= stats[sp_r[pffrs_pkg::PageW-1:0]].recs;
            fr_r <= stats[sp_r[pffrs_pkg::PageW-1:0]].free;
            ls_r <= (sp_r + 1'b1 == used_r);
          end
          ov_r <= (used_r != '0) && (sp_r + 1'b1 != used_r);
          sp_r <= sp_r + 1'b1;
        end
        S_OUT: if (out_tready) begin
          out_tvalid <= 1'b0;
          state_r <= (mode_r == pffrs_pkg::ModeStatus && ov_r) ? S_STAT : S_IDLE;
          ov_r <= 1'b0;
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_IDLE) ov_r <= 1'b0;
    end
  end

  assign o_outcome = oc_r;
  assign o_page = pg_r;
  assign o_slot = sl_r;
  assign o_total = used_r;
  assign o_recs = rc_r;
  assign o_free = fr_r;
  assign o_last = ls_r;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic [2:0]                   outcome;
    logic [pffrs_pkg::PageW-1:0]  page;
    logic [pffrs_pkg::SlotW-1:0]  slot;
    logic [pffrs_pkg::CountW-1:0] total;
    logic [pffrs_pkg::CountW-1:0] recs;
    logic [pffrs_pkg::FreeW-1:0]  free;
    logic                         last;
  } page_result_t;

  // Tracks the page table and holds the results still owed by the block.
  class page_store_board;
    logic [pffrs_pkg::SizeW-1:0]  page_size;
    logic [pffrs_pkg::CountW-1:0] pages_used;
    logic [pffrs_pkg::CountW-1:0] slot_cnt [pffrs_pkg::MaxPages];
    logic [pffrs_pkg::FreeW-1:0]  free_cnt [pffrs_pkg::MaxPages];
    logic [pffrs_pkg::KeyW-1:0]   keys [pffrs_pkg::MaxPages*pffrs_pkg::MaxSlots];
    page_result_t                 owed [$];
    int                           errors;

    function new();
      page_size  = 13'd100;
      pages_used = '0;
      errors     = 0;
      foreach (slot_cnt[i]) slot_cnt[i] = '0;
    endfunction

    function bit add_page();
      int f;
      if (pages_used >= pffrs_pkg::MaxPages) return 0;
      f = (int'(page_size) > pffrs_pkg::HeaderBytes) ?
          int'(page_size) - pffrs_pkg::HeaderBytes : 0;
      if (f > int'(pffrs_pkg::FreeLimit)) f = int'(pffrs_pkg::FreeLimit);
      free_cnt[pages_used] = f[pffrs_pkg::FreeW-1:0];
      slot_cnt[pages_used] = '0;
      pages_used++;
      return 1;
    endfunction

    function bit place(int p, logic [pffrs_pkg::SizeW-1:0] size,
                       logic [pffrs_pkg::KeyW-1:0] key);
      int need;
      need = int'(size) + pffrs_pkg::SlotOverhead;
      if (need > int'(free_cnt[p]) || slot_cnt[p] >= pffrs_pkg::MaxSlots) return 0;
      keys[p*pffrs_pkg::MaxSlots + int'(slot_cnt[p])] = key;
      slot_cnt[p]++;
      free_cnt[p] = free_cnt[p] - need[pffrs_pkg::FreeW-1:0];
      return 1;
    endfunction

    function void owe(logic [2:0] oc, int pg, int sl, int recs, int fr, bit lst);
      page_result_t r;
      r.outcome = oc;
      r.page    = pg[pffrs_pkg::PageW-1:0];
      r.slot    = sl[pffrs_pkg::SlotW-1:0];
      r.total   = pages_used;
      r.recs    = recs[pffrs_pkg::CountW-1:0];
      r.free    = fr[pffrs_pkg::FreeW-1:0];
      r.last    = lst;
      owed.insert(owed.size(), r);
    endfunction

    function void owe_placed(int p);
      owe(pffrs_pkg::OutOk, p, int'(slot_cnt[p]) - 1, int'(slot_cnt[p]),
          int'(free_cnt[p]), 1);
    endfunction

    function void note_request(logic [1:0] mode, logic [pffrs_pkg::SizeW-1:0] size,
                               logic [pffrs_pkg::KeyW-1:0] key);
      int p;
      if (mode == pffrs_pkg::ModeInsert) begin
        if (pages_used == 0 && !add_page()) begin
          owe(pffrs_pkg::OutFull, 0, 0, 0, 0, 1);
          return;
        end
        for (p = 0; p < pages_used; p++)
          if (place(p, size, key)) begin
            owe_placed(p);
            return;
          end
        if (!add_page()) begin
          owe(pffrs_pkg::OutFull, 0, 0, 0, 0, 1);
          return;
        end
        p = int'(pages_used) - 1;
        if (place(p, size, key)) owe_placed(p);
        else owe(pffrs_pkg::OutNoFit, 0, 0, 0, 0, 1);
      end else if (mode == pffrs_pkg::ModeSearch) begin
        for (p = 0; p < pages_used; p++)
          for (int s = 0; s < slot_cnt[p]; s++)
            if (keys[p*pffrs_pkg::MaxSlots + s] == key) begin
              owe(pffrs_pkg::OutOk, p, s, 0, 0, 1);
              return;
            end
        owe(pffrs_pkg::OutNotFound, 0, 0, 0, 0, 1);
      end else if (mode == pffrs_pkg::ModeStatus) begin
        if (pages_used == 0) owe(pffrs_pkg::OutNoPages, 0, 0, 0, 0, 1);
        else
          for (p = 0; p < pages_used; p++)
            owe(pffrs_pkg::OutOk, p, 0, int'(slot_cnt[p]), int'(free_cnt[p]),
                p + 1 == pages_used);
      end
    endfunction

    function void check_result(logic [39:0] data, logic lst);
      page_result_t w;
      bit bad;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transfer: data %h last %b", data, lst);
        return;
      end
      w = owed.pop_front();
      bad = data[2:0] != w.outcome || data[6:3] != w.page || data[10:7] != w.slot ||
            data[15:11] != w.total || data[20:16] != w.recs ||
            data[32:21] != w.free || lst != w.last;
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp oc %0d pg %0d sl %0d tot %0d rec %0d free %0d last %b",
                   w.outcome, w.page, w.slot, w.total, w.recs, w.free, w.last);
          $display("          got oc %0d pg %0d sl %0d tot %0d rec %0d free %0d last %b",
                   data[2:0], data[6:3], data[10:7], data[15:11], data[20:16],
                   data[32:21], lst);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tready;
  logic        out_tvalid;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  page_store_board board;
  bit              idle_on;
  bit              hold_req;
  logic [pffrs_pkg::KeyW-1:0] key_pool [8];

  page_first_fit_record_store_top dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tlast);

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_tready = 0;
    forever begin
      if (hold_req) begin
        out_tready <= 0;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_tready <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic send(logic [1:0] mode, logic [pffrs_pkg::SizeW-1:0] size,
                      logic [pffrs_pkg::KeyW-1:0] key);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {1'b0, key, size, mode};
    do @(posedge clk); while (!in_tready);
    board.note_request(mode, size, key);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (board.owed.size() != 0) @(posedge clk);
    // Leave the block idle for a while before the next configuration write.
    repeat (40) @(posedge clk);
  endtask

  task automatic write_page_size(logic [pffrs_pkg::SizeW-1:0] value);
    cfg_psel    <= 1;
    cfg_pwrite  <= 1;
    cfg_penable <= 0;
    cfg_paddr   <= {pffrs_pkg::RegPageSize, 1'b0};
    cfg_pwdata  <= {19'd0, value};
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel    <= 0;
    cfg_penable <= 0;
    board.page_size = value;
  endtask

  function automatic logic [pffrs_pkg::KeyW-1:0] pick_key();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3:    return key_pool[$urandom_range(0, 7)];
      default: return $urandom();
    endcase
  endfunction

  task automatic random_items(int count);
    logic [pffrs_pkg::KeyW-1:0] k;
    logic [pffrs_pkg::SizeW-1:0] sz;
    int m;
    repeat (count) begin
      m = $urandom_range(0, 19);
      k = pick_key();
      sz = ($urandom_range(0, 9) == 0) ? pffrs_pkg::SizeW'($urandom_range(0, 8191))
                                       : pffrs_pkg::SizeW'($urandom_range(0, 40));
      if (m < 10) begin
        send(pffrs_pkg::ModeInsert, sz, k);
        key_pool[$urandom_range(0, 7)] = k;
      end else if (m < 16) send(pffrs_pkg::ModeSearch, sz, k);
      else if (m < 19) send(pffrs_pkg::ModeStatus, sz, k);
      else send(pffrs_pkg::ModeNone, sz, k);
    end
  endtask

  initial begin
    board = new();
    foreach (key_pool[i]) key_pool[i] = $urandom();
    idle_on = 0;
    hold_req = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty store cases, oversize record, extremes, ignored mode.
    send(pffrs_pkg::ModeStatus, 13'd0, 32'd0);
    send(pffrs_pkg::ModeSearch, 13'd0, 32'h8000_0000);
    send(pffrs_pkg::ModeInsert, 13'h1fff, 32'h7fff_ffff);
    send(pffrs_pkg::ModeInsert, 13'd0, 32'h8000_0000);
    send(pffrs_pkg::ModeInsert, 13'd80, 32'h7fff_ffff);
    send(pffrs_pkg::ModeInsert, 13'd81, 32'h1234_5678);
    send(pffrs_pkg::ModeInsert, 13'd12, 32'hffff_ffff);
    send(pffrs_pkg::ModeSearch, 13'd0, 32'h7fff_ffff);
    send(pffrs_pkg::ModeSearch, 13'd0, 32'hffff_ffff);
    send(pffrs_pkg::ModeSearch, 13'd0, 32'h0000_0001);
    send(pffrs_pkg::ModeNone, 13'h1fff, 32'hffff_ffff);
    send(pffrs_pkg::ModeStatus, 13'h1fff, 32'hffff_ffff);
    drain();

    write_page_size(13'd16);
    send(pffrs_pkg::ModeInsert, 13'd0, 32'd5);
    send(pffrs_pkg::ModeStatus, 13'd0, 32'd0);
    drain();
    write_page_size(13'h1fff);
    send(pffrs_pkg::ModeInsert, 13'd4076, 32'd6);
    send(pffrs_pkg::ModeInsert, 13'd0, 32'd7);
    drain();
    write_page_size(13'd0);
    send(pffrs_pkg::ModeInsert, 13'd1, 32'd8);
    drain();

    idle_on = 1;
    write_page_size(13'd4096);
    random_items(60);
    hold_req = 1;
    random_items(40);
    drain();
    write_page_size(13'd200);
    random_items(100);
    drain();
    write_page_size(13'd16);
    random_items(60);
    drain();
    write_page_size(pffrs_pkg::SizeW'($urandom_range(17, 4095)));
    random_items(110);
    idle_on = 0;
    random_items(70);
    drain();

    if (board.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pffrs_pkg.sv
rtl/core/pffrs_cell.sv
rtl/core/pffrs_ctrl.sv
rtl/core/page_first_fit_record_store_top.sv
test/testbench.sv
